### design/bis_pkg.sv
// Package for the bilinear image scaler.
// Holds the shared constants, register index codes and the pipeline item struct.
// No dependencies.
package bis_pkg;

  // Item kinds
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // Fixed field widths
  localparam int DIM_W   = 15;  // scaled size width
  localparam int FRM_W   = 13;  // frame size width
  localparam int OFS_W   = 16;  // offset width
  localparam int SRC_W   = 9;   // source size register width
  localparam int COORD_W = 12;  // frame coordinate width

  // Configuration register indexes (word address)
  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_SCALED_WIDTH  = 3'd2,
    REG_SCALED_HEIGHT = 3'd3,
    REG_OFFSET_X      = 3'd4,
    REG_OFFSET_Y      = 3'd5,
    REG_FRAME_WIDTH   = 3'd6,
    REG_FRAME_HEIGHT  = 3'd7
  } reg_idx_t;

  // Item travelling down the pipeline alongside the divider
  typedef struct packed {
    logic        valid;
    logic        action;
    logic        in_rect;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] pixel;
  } meta_t;

endpackage

### design/bis_if.sv
// Request and result channel interfaces for the bilinear image scaler.
// Valid/ready handshake with payload; no package dependency.
interface bis_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  src_col;
  logic [7:0]  src_row;
  logic [31:0] src_pixel;
  logic [11:0] frame_col;
  logic [11:0] frame_row;

  modport source (output valid, action, src_col, src_row, src_pixel, frame_col, frame_row,
                  input ready);
  modport sink   (input valid, action, src_col, src_row, src_pixel, frame_col, frame_row,
                  output ready);
endinterface

interface bis_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        inside_res;

  modport source (output valid, out_pixel, inside_res, input ready);
  modport sink   (input valid, out_pixel, inside_res, output ready);
endinterface

### design/bis_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read the old word into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

### design/bis_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit in QW bits; no package dependency.
module bis_div #(
  parameter int NW = 31,
  parameter int DW = 15,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q
);

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] quo [QW];
  logic [QW-1:0] low [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] prev_r;
    logic [QW-1:0] prev_q;
    logic [QW-1:0] prev_low;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign prev_r   = DW'(n >> QW);
      assign prev_q   = '0;
      assign prev_low = n[QW-1:0];
    end else begin : g_next
      assign prev_r   = rem[k-1];
      assign prev_q   = quo[k-1];
      assign prev_low = low[k-1];
    end

    // Shift in next numerator bit, subtract when it fits
    assign trial = {prev_r, prev_low[QW-1-k]};
    assign ge    = trial >= {1'b0, d};
    assign diff  = trial - {1'b0, d};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo[k] <= {prev_q[QW-2:0], ge};
        low[k] <= prev_low;
      end
    end
  end

  assign q = quo[QW-1];

endmodule

### design/bilinear_image_scaler.sv
// Bilinear image scaler top level: config registers, mapping, banked source store,
// interpolation. Depends on bis_pkg, bis_if, bis_ram, bis_div.
//
//  channel | kind      | moves
//  --------+-----------+---------------------------------------------
//  req     | sink      | write of one source pixel, or frame request
//  res     | source    | interpolated pixel and inside flag
//  apb     | cfg slave | eight size/offset/frame registers
//
// One request per cycle while the output is not held; pipeline depth is set mainly by the
// bit-per-stage coordinate divider (QW = 8 + bits of the larger source dimension).
// Four parity banks deliver all four neighbours in one read.
// Reset clears control state only; the source store holds garbage until written.
// A result held in the output register freezes the whole pipeline until taken.
module bilinear_image_scaler #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  bis_in_if.sink      req,
  bis_out_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SWB = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHB = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int QW  = (SWB > SHB ? SWB : SHB) + 8;
  localparam int NW  = QW + 15;
  localparam int IPW = QW - 7;
  localparam int XW  = $clog2(MAX_SRC_WIDTH);
  localparam int YW  = $clog2(MAX_SRC_HEIGHT);
  localparam int HW  = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HH  = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BD  = HW * HH;
  localparam int AW  = BD > 1 ? $clog2(BD) : 1;

  // ---------------- configuration registers ----------------
  logic [bis_pkg::SRC_W-1:0]        src_w, src_h;
  logic [bis_pkg::DIM_W-1:0]        scl_w, scl_h;
  logic signed [bis_pkg::OFS_W-1:0] off_x, off_y;
  logic [bis_pkg::FRM_W-1:0]        frm_w, frm_h;
  logic                             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= 9'd256;
      src_h <= 9'd256;
      scl_w <= 15'd256;
      scl_h <= 15'd256;
      off_x <= '0;
      off_y <= '0;
      frm_w <= 13'd1100;
      frm_h <= 13'd700;
    end else if (cfg_we) begin
      case (bis_pkg::reg_idx_t'(paddr[4:2]))
        bis_pkg::REG_SOURCE_WIDTH:  src_w <= pwdata[8:0];
        bis_pkg::REG_SOURCE_HEIGHT: src_h <= pwdata[8:0];
        bis_pkg::REG_SCALED_WIDTH:  scl_w <= pwdata[14:0];
        bis_pkg::REG_SCALED_HEIGHT: scl_h <= pwdata[14:0];
        bis_pkg::REG_OFFSET_X:      off_x <= pwdata[15:0];
        bis_pkg::REG_OFFSET_Y:      off_y <= pwdata[15:0];
        bis_pkg::REG_FRAME_WIDTH:   frm_w <= pwdata[12:0];
        bis_pkg::REG_FRAME_HEIGHT:  frm_h <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (bis_pkg::reg_idx_t'(paddr[4:2]))
      bis_pkg::REG_SOURCE_WIDTH:  prdata = 32'(src_w);
      bis_pkg::REG_SOURCE_HEIGHT: prdata = 32'(src_h);
      bis_pkg::REG_SCALED_WIDTH:  prdata = 32'(scl_w);
      bis_pkg::REG_SCALED_HEIGHT: prdata = 32'(scl_h);
      bis_pkg::REG_OFFSET_X:      prdata = 32'(off_x);
      bis_pkg::REG_OFFSET_Y:      prdata = 32'(off_y);
      bis_pkg::REG_FRAME_WIDTH:   prdata = 32'(frm_w);
      bis_pkg::REG_FRAME_HEIGHT:  prdata = 32'(frm_h);
      default:                    prdata = '0;
    endcase
  end

  // Effective sizes: zero counts as one, source saturates at store size
  logic [SWB-1:0]            sw_eff;
  logic [SHB-1:0]            sh_eff;
  logic [bis_pkg::DIM_W-1:0] dw_eff, dh_eff;

  always_comb begin
    if (src_w == '0) sw_eff = SWB'(1);
    else if (32'(src_w) > MAX_SRC_WIDTH) sw_eff = SWB'(MAX_SRC_WIDTH);
    else sw_eff = SWB'(src_w);
    if (src_h == '0) sh_eff = SHB'(1);
    else if (32'(src_h) > MAX_SRC_HEIGHT) sh_eff = SHB'(MAX_SRC_HEIGHT);
    else sh_eff = SHB'(src_h);
    dw_eff = (scl_w == '0) ? 15'd1 : scl_w;
    dh_eff = (scl_h == '0) ? 15'd1 : scl_h;
  end

  // ---------------- pipeline enable ----------------
  logic en;
  assign en        = !res.valid || res.ready;
  assign req.ready = en;

  // Stage 1: accepted request
  logic        s1_valid, s1_action;
  logic [7:0]  s1_col, s1_row;
  logic [31:0] s1_pixel;
  logic [11:0] s1_fcol, s1_frow;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_action <= req.action;
      s1_col    <= req.src_col;
      s1_row    <= req.src_row;
      s1_pixel  <= req.src_pixel;
      s1_fcol   <= req.frame_col;
      s1_frow   <= req.frame_row;
    end
  end

  // Stage 2: rectangle test and divider numerators (2t+1)*src*128
  logic signed [17:0] tx, ty;
  logic               in_x, in_y;
  logic [15:0]        ux, uy;
  logic [NW-1:0]      prod_x, prod_y;
  bis_pkg::meta_t     s2_meta;
  logic [NW-1:0]      s2_nx, s2_ny;

  always_comb begin
    tx     = $signed({6'b0, s1_fcol}) - 18'(off_x);
    ty     = $signed({6'b0, s1_frow}) - 18'(off_y);
    in_x   = !tx[17] && (tx[16:0] < 17'(dw_eff)) && (13'(s1_fcol) < frm_w);
    in_y   = !ty[17] && (ty[16:0] < 17'(dh_eff)) && (13'(s1_frow) < frm_h);
    ux     = {tx[14:0], 1'b1};
    uy     = {ty[14:0], 1'b1};
    prod_x = NW'(ux) * NW'(sw_eff);
    prod_y = NW'(uy) * NW'(sh_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_meta <= '0;
    end else if (en) begin
      s2_meta.valid   <= s1_valid;
      s2_meta.action  <= s1_action;
      s2_meta.in_rect <= in_x && in_y;
      s2_meta.col     <= s1_col;
      s2_meta.row     <= s1_row;
      s2_meta.pixel   <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_nx <= prod_x << 7;
      s2_ny <= prod_y << 7;
    end
  end

  // Divider stages, item details carried alongside
  logic [QW-1:0]  qx, qy;
  bis_pkg::meta_t mline [QW];

  bis_div #(.NW(NW), .DW(bis_pkg::DIM_W), .QW(QW)) u_div_x (
    .clk(clk), .en(en), .n(s2_nx), .d(dw_eff), .q(qx)
  );
  bis_div #(.NW(NW), .DW(bis_pkg::DIM_W), .QW(QW)) u_div_y (
    .clk(clk), .en(en), .n(s2_ny), .d(dh_eff), .q(qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) mline[k] <= '0;
    end else if (en) begin
      mline[0] <= s2_meta;
      for (int k = 1; k < QW; k++) mline[k] <= mline[k-1];
    end
  end

  // Map stage: position minus half pixel, clamp neighbours
  function automatic logic [IPW-1:0] clampi(logic signed [IPW-1:0] v,
                                            logic signed [IPW-1:0] hi);
    logic [IPW-1:0] r;
    if (v < 0) r = '0;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  bis_pkg::meta_t     mm;
  logic signed [QW:0] px, py;
  logic signed [IPW-1:0] ipx, ipy, hix, hiy;
  logic [XW-1:0]      x0, x1, xe, xo, wx;
  logic [YW-1:0]      y0, y1, ye, yo, wy;
  logic [7:0]         fx, fy;
  logic               wr_ok;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      baddr [4];
  logic               bwe   [4];
  logic [31:0]        bdata [4];

  always_comb begin
    mm    = mline[QW-1];
    px    = $signed({1'b0, qx}) - (QW+1)'(128);
    py    = $signed({1'b0, qy}) - (QW+1)'(128);
    fx    = px[7:0];
    fy    = py[7:0];
    ipx   = px[QW:8];
    ipy   = py[QW:8];
    hix   = $signed(IPW'(sw_eff) - IPW'(1));
    hiy   = $signed(IPW'(sh_eff) - IPW'(1));
    x0    = XW'(clampi(ipx, hix));
    x1    = XW'(clampi(ipx + IPW'(1), hix));
    y0    = YW'(clampi(ipy, hiy));
    y1    = YW'(clampi(ipy + IPW'(1), hiy));
    // Even and odd member of each neighbour pair
    xe    = x0[0] ? x1 : x0;
    xo    = x0[0] ? x0 : x1;
    ye    = y0[0] ? y1 : y0;
    yo    = y0[0] ? y0 : y1;
    wx    = XW'(mm.col);
    wy    = YW'(mm.row);
    wr_ok = mm.valid && (mm.action == bis_pkg::ACT_WRITE) &&
            (32'(mm.col) < MAX_SRC_WIDTH) && (32'(mm.row) < MAX_SRC_HEIGHT);
    waddr = AW'(32'(wy >> 1) * HW + 32'(wx >> 1));
  end

  // Four parity banks: index bit 1 is row parity, bit 0 column parity
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-1:0] rc;
    logic [YW-1:0] rr;
    assign rc = b[0] ? xo : xe;
    assign rr = b[1] ? yo : ye;
    assign bwe[b]   = en && wr_ok && (wy[0] == b[1]) && (wx[0] == b[0]);
    assign baddr[b] = (mm.action == bis_pkg::ACT_WRITE) ? waddr
                      : AW'(32'(rr >> 1) * HW + 32'(rc >> 1));

    bis_ram #(.WIDTH(32), .DEPTH(BD)) u_ram (
      .clk(clk), .en(en), .we(bwe[b]), .addr(baddr[b]),
      .wdata(mm.pixel), .rdata(bdata[b])
    );
  end

  // Read stage: neighbour parities and fractions wait for the RAM
  logic       r_valid, r_inside;
  logic [7:0] r_fx, r_fy;
  logic       r_x0p, r_x1p, r_y0p, r_y1p;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= mm.valid && (mm.action == bis_pkg::ACT_REQUEST);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_inside <= mm.in_rect;
      r_fx     <= fx;
      r_fy     <= fy;
      r_x0p    <= x0[0];
      r_x1p    <= x1[0];
      r_y0p    <= y0[0];
      r_y1p    <= y1[0];
    end
  end

  // Horizontal blend per channel
  logic [31:0] p00, p01, p10, p11;
  logic [15:0] ha [4];
  logic [15:0] hb [4];
  logic [8:0]  wfx;

  always_comb begin
    p00 = bdata[{r_y0p, r_x0p}];
    p01 = bdata[{r_y0p, r_x1p}];
    p10 = bdata[{r_y1p, r_x0p}];
    p11 = bdata[{r_y1p, r_x1p}];
    wfx = 9'd256 - 9'(r_fx);
    for (int c = 0; c < 4; c++) begin
      ha[c] = 16'(17'(p00[c*8 +: 8]) * 17'(wfx) + 17'(p01[c*8 +: 8]) * 17'(r_fx));
      hb[c] = 16'(17'(p10[c*8 +: 8]) * 17'(wfx) + 17'(p11[c*8 +: 8]) * 17'(r_fx));
    end
  end

  logic        a_valid, a_inside;
  logic [7:0]  a_fy;
  logic [15:0] a_a [4];
  logic [15:0] a_b [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_inside <= r_inside;
      a_fy     <= r_fy;
      a_a      <= ha;
      a_b      <= hb;
    end
  end

  // Vertical blend
  logic [8:0]  wfy;
  logic [23:0] vv [4];

  always_comb begin
    wfy = 9'd256 - 9'(a_fy);
    for (int c = 0; c < 4; c++) begin
      vv[c] = 24'(25'(a_a[c]) * 25'(wfy) + 25'(a_b[c]) * 25'(a_fy));
    end
  end

  logic        v_valid, v_inside;
  logic [23:0] v_v [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
    end else if (en) begin
      v_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_inside <= a_inside;
      v_v      <= vv;
    end
  end

  // Round, clamp and pack
  logic [24:0] rsum [4];
  logic [31:0] pix_next;

  always_comb begin
    pix_next = '0;
    for (int c = 0; c < 4; c++) begin
      rsum[c] = 25'(v_v[c]) + 25'd32768;
      pix_next[c*8 +: 8] = (rsum[c][24:16] > 9'd255) ? 8'd255 : rsum[c][23:16];
    end
    if (!v_inside) pix_next = '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_pixel  <= pix_next;
      res.inside_res <= v_inside;
    end
  end

  // ---------------- assertions ----------------
  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.inside_res |-> res.out_pixel == '0)
    else $error("pixel outside rectangle not zero");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(r_valid) && $stable(a_valid) && $stable(v_valid))
    else $error("pipeline moved while result held");

  a_write_moving: assert property (@(posedge clk) disable iff (rst)
    (bwe[0] || bwe[1] || bwe[2] || bwe[3]) |-> en && mm.action == bis_pkg::ACT_WRITE)
    else $error("store written outside a write item");

endmodule
